// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/kst_pkg.sv =====
package kst_pkg;

    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [0:0] {
        OP_SET    = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED  = 3'd0,
        ST_APPENDED = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        status_t                status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } result_t;

endpackage

// ===== rtl/core/kst_ram.sv =====
module kst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/kst_front.sv =====
module kst_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic           cmd,
    input  logic [31:0]    key,
    input  logic [31:0]    new_value,
    output kst_pkg::item_t q_item,
    output logic           q_valid,
    input  logic           q_take
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    kst_pkg::item_t   slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push_fire;
    logic             take_fire;
    kst_pkg::item_t   in_item;

    assign full      = (cnt_reg == CNT_W'(QDEPTH));
    assign q_valid   = (cnt_reg != '0);
    assign q_item    = slot_reg[rd_ptr_reg];
    assign push_fire = push && !full;
    assign take_fire = q_take && q_valid;

    // Decode the raw command bit into an operation code on the way in.
    always_comb
    begin
        in_item.op    = kst_pkg::op_t'(cmd);
        in_item.key   = key;
        in_item.value = new_value;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (take_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push_fire && !take_fire)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (take_fire && !push_fire)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/kst_engine.sv =====
module kst_engine #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  kst_pkg::item_t   q_item,
    input  logic             q_valid,
    output logic             q_take,
    input  logic             pop,
    output kst_pkg::result_t res,
    output logic             res_valid
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SEARCH  = 4'b0010,
        S_RESOLVE = 4'b0100,
        S_MOVE    = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    kst_pkg::op_t                   op_reg, op_next;
    logic [kst_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [kst_pkg::VALUE_W-1:0]    val_reg, val_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic                           hit_reg, hit_next;
    logic [CW-1:0]                  count_reg, count_next;
    kst_pkg::result_t               res_reg, res_next;
    logic                           res_valid_reg, res_valid_next;

    logic [CW-1:0]                  last_idx;
    logic                           finish_ok;
    logic [AW-1:0]                  rd_addr;
    logic [AW-1:0]                  wr_addr;
    logic                           key_we;
    logic                           val_we;
    logic [kst_pkg::KEY_W-1:0]      key_wdata;
    logic [kst_pkg::VALUE_W-1:0]    val_wdata;
    logic [kst_pkg::KEY_W-1:0]      key_rdata;
    logic [kst_pkg::VALUE_W-1:0]    val_rdata;

    kst_ram #(.WIDTH(kst_pkg::KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    kst_ram #(.WIDTH(kst_pkg::VALUE_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    assign last_idx  = CW'(count_reg - 1'b1);
    assign finish_ok = !res_valid_reg || pop;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    // The search issues the next address while it compares the data of the
    // previous one, so one entry is checked per cycle.
    always_comb
    begin
        case (state_reg)
            S_SEARCH:  rd_addr = AW'(idx_reg + 1'b1);
            S_RESOLVE: rd_addr = AW'(last_idx);
            S_MOVE:    rd_addr = AW'(last_idx);
            default:   rd_addr = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        q_take         = 1'b0;
        key_we         = 1'b0;
        val_we         = 1'b0;
        wr_addr        = idx_reg;
        key_wdata      = key_reg;
        val_wdata      = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_take     = 1'b1;
                    op_next    = q_item.op;
                    key_next   = q_item.key;
                    val_next   = q_item.value;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = (count_reg == '0) ? S_RESOLVE : S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if (key_rdata == key_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = S_RESOLVE;
                end
                else if (CW'(idx_reg) == last_idx)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    idx_next = AW'(idx_reg + 1'b1);
                end
            end

            S_RESOLVE:
            begin
                if (op_reg == kst_pkg::OP_REMOVE && hit_reg && CW'(idx_reg) != last_idx)
                begin
                    // The last entry is being read now and fills the hole in S_MOVE once the result slot is free.
                    state_next = S_MOVE;
                end
                else if (finish_ok)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (op_reg == kst_pkg::OP_SET)
                    begin
                        if (hit_reg)
                        begin
                            val_we          = 1'b1;
                            res_next.status = kst_pkg::ST_UPDATED;
                        end
                        else if (count_reg == FULL_COUNT)
                        begin
                            res_next.status = kst_pkg::ST_FULL;
                        end
                        else
                        begin
                            key_we          = 1'b1;
                            val_we          = 1'b1;
                            wr_addr         = AW'(count_reg);
                            count_next      = CW'(count_reg + 1'b1);
                            res_next.status = kst_pkg::ST_APPENDED;
                        end
                    end
                    else if (hit_reg)
                    begin
                        count_next      = last_idx;
                        res_next.status = kst_pkg::ST_REMOVED;
                    end
                    else
                    begin
                        res_next.status = kst_pkg::ST_ABSENT;
                    end
                    res_next.entry_count = kst_pkg::COUNT_OUT_W'(count_next);
                end
            end

            S_MOVE:
            begin
                if (finish_ok)
                begin
                    key_we               = 1'b1;
                    val_we               = 1'b1;
                    key_wdata            = key_rdata;
                    val_wdata            = val_rdata;
                    count_next           = last_idx;
                    res_valid_next       = 1'b1;
                    res_next.status      = kst_pkg::ST_REMOVED;
                    res_next.entry_count = kst_pkg::COUNT_OUT_W'(last_idx);
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        res_reg <= res_next;
    end

endmodule

// ===== rtl/core/keyed_state_table_set_remove_top.sv =====
// The engine scans the stored entries one per cycle, up to TABLE_DEPTH of them,
// through the single key memory read port; a remove that moves the last entry into
// the freed slot passes through an extra move state. The engine handles one command
// at a time, and a two-entry input queue keeps accepting while the engine searches.
// Reset (rst_n, asynchronous, active low) empties the table, queue and result slot.
module keyed_state_table_set_remove_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        cmd,
    input  logic [31:0] key,
    input  logic [31:0] new_value,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [6:0]  entry_count
);

    kst_pkg::item_t   q_item;
    logic             q_valid;
    logic             q_take;
    kst_pkg::result_t res;
    logic             res_valid;

    kst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .key       (key),
        .new_value (new_value),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_take    (q_take)
    );

    kst_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .pop       (pop),
        .res       (res),
        .res_valid (res_valid)
    );

    assign empty       = !res_valid;
    assign status      = res.status;
    assign entry_count = res.entry_count;

endmodule

// ===== rtl/core/kst_checker.sv =====
`include "assert_macros.svh"

module kst_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] status,
    input logic [6:0] entry_count
);

    localparam logic [6:0] FULL_SHOWN = 7'(TABLE_DEPTH);

    logic       drop_seen;
    logic       append_seen;
    logic       res_held;
    logic [9:0] result_word;

    assign drop_seen   = !empty && (status == kst_pkg::ST_FULL);
    assign append_seen = !empty && (status == kst_pkg::ST_APPENDED);
    assign res_held    = !empty && !pop;
    assign result_word = {status, entry_count};

    // A dropped set can only happen when every entry is filled.
    `ASSERT_RST(a_full_count, clk, rst_n, drop_seen |-> entry_count == FULL_SHOWN, "drop below full")
    // An append leaves at least one entry behind it.
    `ASSERT_RST(a_append_nonzero, clk, rst_n, append_seen |-> entry_count != 7'd0, "append left zero")
    // Leaving reset, no result can be waiting.
    `ASSERT_ALWAYS(a_reset_empty, clk, $rose(rst_n) |-> empty, "result present right after reset")
    // A result that is not taken stays as it is.
    `ASSERT_RST(a_hold, clk, rst_n, res_held |=> !empty && $stable(result_word), "result changed")

endmodule

bind keyed_state_table_set_remove_top kst_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_kst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .entry_count (entry_count)
);
